// ===== design/sbpf_pkg.sv =====
// shared types and constants for the servo bus packet framer
`default_nettype none
package sbpf_pkg;

  // frame constants
  localparam logic [7:0] SYNC_BYTE      = 8'h55;
  localparam logic [8:0] FRAME_OVERHEAD = 9'd6;
  localparam logic [7:0] LEN_OVERHEAD   = 8'd3;
  localparam logic [7:0] CAP_RESET      = 8'd255;

  // input command codes
  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_PARAM = 1'b1;

  // result status codes
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // job queue depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // input word
  typedef struct packed {
    logic       command;
    logic [7:0] target_id;
    logic [7:0] servo_command;
    logic [7:0] param_count;
    logic [7:0] param_byte;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       status;
  } out_word_t;

  // kinds of work handed from front to back
  typedef enum logic [1:0] {
    JOB_REJECT,
    JOB_HEADER,
    JOB_PARAM
  } job_kind_t;

  // one job: a rejection, header bytes or one parameter byte, plus checksum when last
  typedef struct packed {
    job_kind_t  kind;
    logic       last;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] chk;
  } job_t;

endpackage
`default_nettype wire

// ===== design/sbpf_front.sv =====
// front end: accepts input words, tracks the frame and builds jobs
`default_nettype none
module sbpf_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [7:0]        cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sbpf_pkg::in_word_t in_data,
  input  wire logic              q_full,
  output logic                   q_push,
  output sbpf_pkg::job_t         q_job
);
  import sbpf_pkg::*;

  logic [7:0] capacity_r;
  logic [7:0] params_left_r, params_left_nxt;
  logic [7:0] running_sum_r, running_sum_nxt;
  logic       in_frame_r, in_frame_nxt;

  logic       accept;
  logic [8:0] frame_len;
  logic [7:0] len_byte;
  logic [7:0] hdr_sum;
  logic [7:0] param_sum;

  assign in_ready = ~q_full;
  assign accept   = in_valid & in_ready;

  // arithmetic for begin and parameter words
  assign frame_len = {1'b0, in_data.param_count} + FRAME_OVERHEAD;
  assign len_byte  = in_data.param_count + LEN_OVERHEAD;
  assign hdr_sum   = in_data.target_id + len_byte + in_data.servo_command;
  assign param_sum = running_sum_r + in_data.param_byte;

  // classify the word and build the job
  always_comb begin
    params_left_nxt = params_left_r;
    running_sum_nxt = running_sum_r;
    in_frame_nxt    = in_frame_r;
    q_push          = 1'b0;
    q_job.kind      = JOB_REJECT;
    q_job.last      = 1'b0;
    q_job.b0        = in_data.target_id;
    q_job.b1        = len_byte;
    q_job.b2        = in_data.servo_command;
    q_job.chk       = ~hdr_sum;
    if (accept) begin
      if (in_data.command == CMD_BEGIN) begin
        params_left_nxt = '0;
        running_sum_nxt = '0;
        in_frame_nxt    = 1'b0;
        q_push          = 1'b1;
        if (frame_len > {1'b0, capacity_r}) begin
          q_job.kind = JOB_REJECT;
        end else begin
          q_job.kind = JOB_HEADER;
          q_job.last = (in_data.param_count == '0);
          if (in_data.param_count != '0) begin
            params_left_nxt = in_data.param_count;
            running_sum_nxt = hdr_sum;
            in_frame_nxt    = 1'b1;
          end
        end
      end else if (in_frame_r) begin
        q_push          = 1'b1;
        q_job.kind      = JOB_PARAM;
        q_job.b0        = in_data.param_byte;
        q_job.chk       = ~param_sum;
        q_job.last      = (params_left_r == 8'd1);
        params_left_nxt = params_left_r - 8'd1;
        running_sum_nxt = param_sum;
        if (params_left_r == 8'd1) begin
          running_sum_nxt = '0;
          in_frame_nxt    = 1'b0;
        end
      end
    end
  end

  // frame state and capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r    <= CAP_RESET;
      params_left_r <= '0;
      running_sum_r <= '0;
      in_frame_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
      params_left_r <= params_left_nxt;
      running_sum_r <= running_sum_nxt;
      in_frame_r    <= in_frame_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/sbpf_queue.sv =====
// short job queue between front and back
`default_nettype none
module sbpf_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire sbpf_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output sbpf_pkg::job_t      head_job
);
  import sbpf_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/sbpf_back.sv =====
// back end: expands each job into frame bytes, one per cycle while the output is taken
`default_nettype none
module sbpf_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            head_valid,
  input  wire sbpf_pkg::job_t  head_job,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output sbpf_pkg::out_word_t  out_data
);
  import sbpf_pkg::*;

  logic [2:0] step_r;
  logic       out_valid_r;
  out_word_t  out_r;
  out_word_t  word;
  logic [2:0] last_step;
  logic       advance;

  assign advance   = head_valid & (~out_valid_r | out_ready);
  assign pop       = advance & (step_r == last_step);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // select the byte for the current step
  always_comb begin
    word.frame_byte = '0;
    word.frame_end  = 1'b0;
    word.status     = STATUS_OK;
    last_step       = '0;
    unique case (head_job.kind)
      JOB_HEADER: begin
        last_step = head_job.last ? 3'd5 : 3'd4;
        unique case (step_r)
          3'd0, 3'd1: word.frame_byte = SYNC_BYTE;
          3'd2:       word.frame_byte = head_job.b0;
          3'd3:       word.frame_byte = head_job.b1;
          3'd4:       word.frame_byte = head_job.b2;
          default: begin
            word.frame_byte = head_job.chk;
            word.frame_end  = 1'b1;
          end
        endcase
      end
      JOB_PARAM: begin
        last_step = head_job.last ? 3'd1 : 3'd0;
        if (step_r == 3'd0) begin
          word.frame_byte = head_job.b0;
        end else begin
          word.frame_byte = head_job.chk;
          word.frame_end  = 1'b1;
        end
      end
      default: begin
        word.frame_end = 1'b1;
        word.status    = STATUS_REJECT;
      end
    endcase
  end

  // output register and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        step_r      <= (step_r == last_step) ? 3'd0 : step_r + 3'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= word;
    end
  end

endmodule
`default_nettype wire

// ===== design/servo_bus_packet_framer.sv =====
// Servo bus packet framer: turns begin and parameter words into bus-servo frames
// (0x55 0x55 id len cmd params checksum) with an inverted-sum checksum, or one
// rejection word when param_count + 6 exceeds the capacity register. The front end
// takes one input word per cycle while the two-entry job queue has room; the back
// end emits one frame byte per cycle from its output register while out_ready allows,
// so a parameter word yields one byte (two if last: it adds the checksum) and a begin
// word five or six bytes (one word when rejected). Sustained throughput is set by that
// byte-per-cycle back end and by how fast results are taken. Stray parameter words
// are consumed with no result. Write the capacity only while the block is idle.
`default_nettype none
module servo_bus_packet_framer (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [7:0]          cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire sbpf_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output sbpf_pkg::out_word_t      out_data
);
  import sbpf_pkg::*;

  logic q_push, q_full, q_pop, q_head_valid;
  job_t q_job, q_head_job;

  // accept and classify
  sbpf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  // job queue
  sbpf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  // byte emission
  sbpf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_job   (q_head_job),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// testbench for the servo bus packet framer: queued stimulus, frame byte predictor, word checker
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sbpf_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int PRINT_LIMIT  = 40;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  // pending input words and expected frame words
  in_word_t  in_pend_q[$];
  out_word_t exp_frame_q[$];
  out_word_t mon_want;

  // framer model state
  logic [7:0] cap_model = CAP_RESET;
  logic [7:0] fr_left   = 8'h00;
  logic [7:0] fr_sum    = 8'h00;
  logic       fr_open   = 1'b0;

  // traffic shaping
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int err_cnt   = 0;
  int cycle_cnt = 0;

  servo_bus_packet_framer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    if (err_cnt < PRINT_LIMIT) begin
      $display("%0t ns: %s got %0h want %0h", $time, field, got, want);
    end
    err_cnt++;
  endtask

  task automatic push_frame_word(input logic [7:0] b, input logic fend, input logic st);
    exp_frame_q.push_back('{frame_byte: b, frame_end: fend, status: st});
  endtask

  // expected frame words for one accepted input word
  task automatic predict_frame_words(input in_word_t w);
    logic [7:0] len;
    int frame_len;
    if (w.command == CMD_BEGIN) begin
      fr_open = 1'b0;
      fr_left = 8'h00;
      fr_sum  = 8'h00;
      frame_len = int'(w.param_count) + int'(FRAME_OVERHEAD);
      if (frame_len > int'(cap_model)) begin
        push_frame_word(8'h00, 1'b1, STATUS_REJECT);
      end else begin
        len = w.param_count + LEN_OVERHEAD;
        push_frame_word(SYNC_BYTE, 1'b0, STATUS_OK);
        push_frame_word(SYNC_BYTE, 1'b0, STATUS_OK);
        push_frame_word(w.target_id, 1'b0, STATUS_OK);
        push_frame_word(len, 1'b0, STATUS_OK);
        push_frame_word(w.servo_command, 1'b0, STATUS_OK);
        fr_sum = w.target_id + len + w.servo_command;
        if (w.param_count == 8'h00) begin
          push_frame_word(~fr_sum, 1'b1, STATUS_OK);
          fr_sum = 8'h00;
        end else begin
          fr_left = w.param_count;
          fr_open = 1'b1;
        end
      end
    end else if (fr_open) begin
      push_frame_word(w.param_byte, 1'b0, STATUS_OK);
      fr_sum  = fr_sum + w.param_byte;
      fr_left = fr_left - 8'd1;
      if (fr_left == 8'h00) begin
        push_frame_word(~fr_sum, 1'b1, STATUS_OK);
        fr_sum  = 8'h00;
        fr_open = 1'b0;
      end
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (!in_valid || in_ready) begin
      if (in_pend_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= in_pend_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side ready, with long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // monitor: predict on input accept, check on output accept
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_frame_words(in_data);
      end
      if (out_valid && out_ready) begin
        if (exp_frame_q.size() == 0) begin
          report_mismatch("unexpected word, frame_byte", out_data.frame_byte, 8'h00);
        end else begin
          mon_want = exp_frame_q.pop_front();
          if (out_data.frame_byte !== mon_want.frame_byte)
            report_mismatch("frame_byte", out_data.frame_byte, mon_want.frame_byte);
          if (out_data.frame_end !== mon_want.frame_end)
            report_mismatch("frame_end", 8'(out_data.frame_end), 8'(mon_want.frame_end));
          if (out_data.status !== mon_want.status)
            report_mismatch("status", 8'(out_data.status), 8'(mon_want.status));
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("servo_bus_packet_framer: mismatch");
      $finish;
    end
  end

  function automatic in_word_t mk_begin(input logic [7:0] id, input logic [7:0] scmd,
                                        input logic [7:0] cnt, input logic [7:0] pb);
    in_word_t w;
    w.command       = CMD_BEGIN;
    w.target_id     = id;
    w.servo_command = scmd;
    w.param_count   = cnt;
    w.param_byte    = pb;
    return w;
  endfunction

  function automatic in_word_t mk_param(input logic [7:0] pb);
    in_word_t w;
    w = mk_begin(8'h00, 8'h00, 8'h00, pb);
    w.command = CMD_PARAM;
    return w;
  endfunction

  function automatic in_word_t rand_word(input logic cmd);
    in_word_t w;
    w.command       = cmd;
    w.target_id     = 8'($urandom_range(0, 255));
    w.servo_command = 8'($urandom_range(0, 255));
    w.param_count   = 8'($urandom_range(0, 255));
    w.param_byte    = 8'($urandom_range(0, 255));
    return w;
  endfunction

  // wait for every word to drain, then for any stray word still in flight
  task automatic wait_idle();
    while (in_pend_q.size() != 0 || in_valid || exp_frame_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [7:0] cap);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
    cap_model = cap;
  endtask

  // mostly whole frames with random content, some cut short, some stray words
  task automatic queue_random_frames(input int n_items);
    int added;
    int r;
    int cnt;
    int n_par;
    in_word_t w;
    added = 0;
    while (added < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        in_pend_q.push_back(rand_word(CMD_PARAM));
        added += 1;
      end else begin
        w = rand_word(CMD_BEGIN);
        if (r < 75) cnt = $urandom_range(0, 8);
        else if (r < 90) cnt = $urandom_range(9, 40);
        else cnt = $urandom_range(0, 255);
        w.param_count = 8'(cnt);
        n_par = (cnt > 40) ? $urandom_range(0, 6) : cnt;
        if ($urandom_range(0, 9) == 0) n_par = $urandom_range(0, n_par);
        in_pend_q.push_back(w);
        repeat (n_par) in_pend_q.push_back(rand_word(CMD_PARAM));
        added += 1 + n_par;
      end
    end
  endtask

  task automatic run_random_phase(input logic [7:0] cap, input int src_pct,
                                  input int snk_pct, input bit with_hold, input int n);
    wait_idle();
    write_capacity(cap);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    if (with_hold) hold_reqs++;
    queue_random_frames(n);
  endtask

  // stimulus sequence
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed frames at reset capacity
    in_pend_q.push_back(mk_begin(8'hFF, 8'hFF, 8'd0, 8'hFF));
    in_pend_q.push_back(mk_begin(8'h00, 8'h00, 8'd0, 8'h00));
    in_pend_q.push_back(mk_begin(8'h01, 8'h03, 8'd2, 8'h00));
    in_pend_q.push_back(mk_param(8'h00));
    in_pend_q.push_back(mk_param(8'hFF));
    in_pend_q.push_back(mk_param(8'hAA));
    // largest count that fits, then abandoned by a new begin
    in_pend_q.push_back(mk_begin(8'hFE, 8'h80, 8'd249, 8'h00));
    in_pend_q.push_back(mk_param(8'h12));
    in_pend_q.push_back(mk_param(8'h34));
    in_pend_q.push_back(mk_begin(8'h10, 8'h20, 8'd250, 8'h00));
    in_pend_q.push_back(mk_begin(8'h10, 8'h20, 8'd255, 8'hFF));
    in_pend_q.push_back(mk_param(8'h77));
    in_pend_q.push_back(mk_begin(8'h55, 8'h55, 8'd1, 8'h00));
    in_pend_q.push_back(mk_param(8'h55));
    in_pend_q.push_back(mk_begin(8'hC3, 8'h3C, 8'd3, 8'h00));
    in_pend_q.push_back(mk_param(8'hFF));
    in_pend_q.push_back(mk_param(8'hFF));
    in_pend_q.push_back(mk_param(8'hFF));

    // smallest legal capacity: only zero-count frames fit
    wait_idle();
    write_capacity(8'd6);
    in_pend_q.push_back(mk_begin(8'h2A, 8'h07, 8'd0, 8'h00));
    in_pend_q.push_back(mk_begin(8'h2A, 8'h07, 8'd1, 8'h00));
    in_pend_q.push_back(mk_param(8'h01));

    // capacity below the frame overhead rejects everything
    wait_idle();
    write_capacity(8'd0);
    in_pend_q.push_back(mk_begin(8'h01, 8'h01, 8'd0, 8'h00));
    in_pend_q.push_back(mk_begin(8'h02, 8'h02, 8'd5, 8'h00));
    in_pend_q.push_back(mk_param(8'h09));

    // random phases: long receiver hold / sender idle / receiver stall / both
    run_random_phase(8'd255, 0, 0, 1'b1, 40);
    run_random_phase(8'd12, 57, 0, 1'b0, 36);
    run_random_phase(8'($urandom_range(6, 255)), 0, 57, 1'b0, 36);
    run_random_phase(8'd40, 25, 25, 1'b0, 36);

    wait_idle();
    if (err_cnt == 0) begin
      $display("servo_bus_packet_framer: match");
    end else begin
      $display("servo_bus_packet_framer: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
